[hw/rtl/matrix_keypad_scanner_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the matrix keypad scanner
// Clocked assertion helpers used by matrix_keypad_scanner.sv.
// ----------------------------------------------------------------------------
`ifndef MATRIX_KEYPAD_SCANNER_DEFINES_SVH
`define MATRIX_KEYPAD_SCANNER_DEFINES_SVH

// Checked on every rising edge of clk, muted while rst is high.
`define MKS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define MKS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/mks_pkg.sv]
// ----------------------------------------------------------------------------
// mks_pkg
// Constants, register map and types of the matrix keypad scanner.
// ----------------------------------------------------------------------------
package mks_pkg;

  localparam int NUM_ROWS = 4;
  localparam int NUM_COLS = 4;

  localparam int PIN_W  = 4;   // sense_columns / row_drive field width
  localparam int KEY_W  = 16;  // key set width
  localparam int CNT_W  = 16;  // settle counter width
  localparam int ROW_W  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(NUM_ROWS - 1);
  localparam logic [PIN_W-1:0] COL_MASK =
    (NUM_COLS >= PIN_W) ? {PIN_W{1'b1}} : PIN_W'((1 << NUM_COLS) - 1);

  localparam logic [CNT_W-1:0] SETTLE_RESET = CNT_W'(48);
  localparam logic [KEY_W-1:0] KEY_MASK_RESET = {KEY_W{1'b1}};

  // Register select, taken from paddr[2]
  localparam logic REG_SETTLE   = 1'b0;
  localparam logic REG_KEY_MASK = 1'b1;

  typedef struct packed {
    logic [PIN_W-1:0] row_drive;
    logic [KEY_W-1:0] held_keys;
    logic             scan_done;
  } res_t;

  // Driven row low, other existing rows high, missing rows read 0
  function automatic logic [PIN_W-1:0] drive_pattern(input logic [ROW_W-1:0] row);
    logic [PIN_W-1:0] pat;
    pat = '0;
    for (int i = 0; i < PIN_W; i++) begin
      pat[i] = (i < NUM_ROWS) && (ROW_W'(i) != row);
    end
    return pat;
  endfunction

endpackage

[hw/rtl/matrix_keypad_scanner.sv]
// ----------------------------------------------------------------------------
// matrix_keypad_scanner
// Row-by-row scanner for a key matrix with settle delay, key enable mask
// and ghost rejection (a scan with more than one key is dropped).
// Throughput: one transaction per cycle while the skid register is empty;
// the output register plus a skid register let input run while one result
// waits downstream. Results are registered.
// Reset (rst, synchronous): row index 3, counters, accumulator and held
// keys cleared, settle_cycles = 48, key_enable_mask = 0xFFFF.
// ----------------------------------------------------------------------------
`include "matrix_keypad_scanner_defines.svh"

module matrix_keypad_scanner
  import mks_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIN_W-1:0]  sense_columns,
  // output channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PIN_W-1:0]  row_drive,
  output logic [KEY_W-1:0]  held_keys,
  output logic              scan_done,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [CNT_W-1:0] settle_cycles;
  logic [KEY_W-1:0] key_enable_mask;

  logic [ROW_W-1:0] row_index, row_index_next;
  logic [CNT_W-1:0] settle_count, settle_count_next;
  logic [KEY_W-1:0] scan_accum, scan_accum_next;
  logic [KEY_W-1:0] held_key_set, held_key_set_next;

  logic             skid_valid;
  res_t             out_res, skid_res, res_next;

  logic             in_xfer;
  logic             cfg_write;
  logic [KEY_W-1:0] sampled;
  logic [KEY_W-1:0] keys;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign in_ready  = !skid_valid;
  assign in_xfer   = in_valid && in_ready;

  always_comb begin
    unique case (paddr[2])
      REG_SETTLE:   prdata = DATA_W'(settle_cycles);
      REG_KEY_MASK: prdata = DATA_W'(key_enable_mask);
      default:      prdata = '0;
    endcase
  end

  // Scan step for one tick
  assign sampled = KEY_W'(scan_accum << NUM_COLS) | KEY_W'(sense_columns & COL_MASK);
  assign keys    = ~sampled & key_enable_mask;

  always_comb begin
    row_index_next    = row_index;
    settle_count_next = settle_count;
    scan_accum_next   = scan_accum;
    held_key_set_next = held_key_set;
    res_next.scan_done = 1'b0;
    if (settle_count < settle_cycles) begin
      settle_count_next = settle_count + 1'b1;
    end else begin
      settle_count_next = '0;
      if (row_index == '0) begin
        // ghost rejection: accept empty or single-key sets only
        if ((keys & (keys - 1'b1)) == '0) begin
          held_key_set_next = keys;
        end
        scan_accum_next    = '0;
        row_index_next     = ROW_LAST;
        res_next.scan_done = 1'b1;
      end else begin
        scan_accum_next = sampled;
        row_index_next  = row_index - 1'b1;
      end
    end
    res_next.row_drive = drive_pattern(row_index);
    res_next.held_keys = held_key_set_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_cycles   <= SETTLE_RESET;
      key_enable_mask <= KEY_MASK_RESET;
      row_index       <= ROW_LAST;
      settle_count    <= '0;
      scan_accum      <= '0;
      held_key_set    <= '0;
      out_valid       <= 1'b0;
      skid_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (paddr[2])
          REG_SETTLE:   settle_cycles   <= pwdata[CNT_W-1:0];
          REG_KEY_MASK: key_enable_mask <= pwdata[KEY_W-1:0];
          default:      ;
        endcase
      end
      if (in_xfer) begin
        row_index    <= row_index_next;
        settle_count <= settle_count_next;
        scan_accum   <= scan_accum_next;
        held_key_set <= held_key_set_next;
      end
      if (out_ready || !out_valid) begin
        out_valid  <= skid_valid || in_xfer;
        skid_valid <= 1'b0;
      end else if (in_xfer) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (in_xfer) begin
        out_res <= res_next;
      end
    end else if (in_xfer) begin
      skid_res <= res_next;
    end
  end

  assign row_drive = out_res.row_drive;
  assign held_keys = out_res.held_keys;
  assign scan_done = out_res.scan_done;

  `MKS_ASSERT(a_skid_needs_out, skid_valid |-> out_valid, "skid entry without output entry")
  `MKS_ASSERT(a_stall_to_skid, (in_xfer && out_valid && !out_ready) |=> skid_valid, "dropped")
  `MKS_ASSERT(a_held_onehot0, $onehot0(held_key_set), "held key set has more than one key")
  `MKS_ASSERT(a_row_range, row_index <= ROW_LAST, "row index out of range")
  `MKS_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid && !skid_valid, "not empty after reset")

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: matrix keypad scanner testbench
// Drives column levels that follow a modeled set of pressed keys, mirrors
// the scan state in a local model and compares every result transaction
// field by field. Covers settle timing, key masking and ghost rejection,
// with register changes between traffic segments and random stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import mks_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 450;
  localparam logic [ADDR_W-1:0] ADDR_SETTLE = {REG_SETTLE, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_KEY_MASK = {REG_KEY_MASK, 2'b00};
  localparam logic [CNT_W-1:0] SETTLE_DEFAULT = 16'd48;
  localparam logic [KEY_W-1:0] MASK_DEFAULT = 16'hFFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [PIN_W-1:0] sense_columns = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PIN_W-1:0] row_drive;
  logic [KEY_W-1:0] held_keys;
  logic scan_done;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  // scanner model state and register mirror
  logic [ROW_W-1:0] cur_row = ROW_LAST;
  logic [CNT_W-1:0] settle_cnt = '0;
  logic [KEY_W-1:0] scan_bits = '0;
  logic [KEY_W-1:0] held_set = '0;
  logic [CNT_W-1:0] settle_cfg = SETTLE_DEFAULT;
  logic [KEY_W-1:0] mask_cfg = MASK_DEFAULT;

  res_t pending_outputs[$];
  res_t oldest;
  logic [KEY_W-1:0] keys_down = '0;
  bit last_done;
  int src_idle_pct = 37;
  int sink_idle_pct = 84;
  int fail_count = 0;
  int cycle_count = 0;

  matrix_keypad_scanner dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .sense_columns(sense_columns),
    .out_valid(out_valid), .out_ready(out_ready),
    .row_drive(row_drive), .held_keys(held_keys), .scan_done(scan_done),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("matrix_keypad_scanner verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_outputs.size() == 0) begin
        $error("result transaction with nothing expected");
        fail_count++;
      end else begin
        oldest = pending_outputs.pop_front();
        if (row_drive !== oldest.row_drive) begin
          $error("row_drive: expected %h, got %h", oldest.row_drive, row_drive);
          fail_count++;
        end
        if (held_keys !== oldest.held_keys) begin
          $error("held_keys: expected %h, got %h", oldest.held_keys, held_keys);
          fail_count++;
        end
        if (scan_done !== oldest.scan_done) begin
          $error("scan_done: expected %b, got %b", oldest.scan_done, scan_done);
          fail_count++;
        end
      end
    end
  end

  // One scan tick: output for this tick, then advance the row/settle state.
  function automatic res_t next_scan_output(input logic [PIN_W-1:0] levels);
    res_t r;
    logic [KEY_W-1:0] keys;
    r.row_drive = ~(PIN_W'(1) << cur_row);
    r.scan_done = 1'b0;
    if (settle_cnt < settle_cfg) begin
      settle_cnt = settle_cnt + 1'b1;
    end else begin
      settle_cnt = '0;
      scan_bits = {scan_bits[KEY_W-NUM_COLS-1:0], levels[NUM_COLS-1:0]};
      if (cur_row == '0) begin
        keys = ~scan_bits & mask_cfg;
        // more than one key looks like ghosting: keep the old set
        if ((keys & (keys - 1'b1)) == '0) held_set = keys;
        scan_bits = '0;
        cur_row = ROW_LAST;
        r.scan_done = 1'b1;
      end else begin
        cur_row = cur_row - 1'b1;
      end
    end
    r.held_keys = held_set;
    return r;
  endfunction

  // Column levels for the row driven now, from keys_down, with optional bounce
  function automatic logic [PIN_W-1:0] scan_columns(input bit noisy);
    logic [PIN_W-1:0] levels;
    levels = '1;
    levels[NUM_COLS-1:0] = ~keys_down[cur_row*NUM_COLS +: NUM_COLS];
    if (noisy) begin
      if (settle_cnt >= settle_cfg) begin
        if ($urandom_range(9) == 0) levels = PIN_W'($urandom_range(15));
      end else if ($urandom_range(1) == 1) begin
        levels = PIN_W'($urandom_range(15));
      end
    end
    return levels;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key_set();
    int a;
    case ($urandom_range(9))
      0, 1: return '0;
      2, 3, 4, 5: return KEY_W'(1) << $urandom_range(KEY_W - 1);
      6, 7: begin
        a = $urandom_range(KEY_W - 1);
        return (KEY_W'(1) << a) | (KEY_W'(1) << ((a + 1 + $urandom_range(KEY_W - 2)) % KEY_W));
      end
      default: return KEY_W'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic send_tick(input logic [PIN_W-1:0] levels);
    res_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sense_columns <= levels;
    do @(posedge clk); while (!in_ready);
    r = next_scan_output(levels);
    last_done = r.scan_done;
    pending_outputs.push_back(r);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_outputs.size() != 0);
  endtask

  task automatic check_reg(input logic [ADDR_W-1:0] addr, input logic [15:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(negedge clk) penable <= 1'b1;
    @(posedge clk);
    if (prdata !== DATA_W'(want)) begin
      $error("prdata @%0h: expected %h, got %h", addr, DATA_W'(want), prdata);
      fail_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= DATA_W'(value);
    @(negedge clk) penable <= 1'b1;
    @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_SETTLE) settle_cfg = value;
    else mask_cfg = value;
    @(negedge clk);
    check_reg(addr, value);
  endtask

  task automatic test_reset_defaults();
    check_reg(ADDR_SETTLE, SETTLE_DEFAULT);
    check_reg(ADDR_KEY_MASK, MASK_DEFAULT);
    keys_down = '0;
    repeat (2) send_tick(scan_columns(1'b0));
  endtask

  // settle 0: every tick samples a row, so a scan is four transactions
  task automatic test_single_key();
    wait_drained();
    write_reg(ADDR_SETTLE, '0);
    keys_down = 16'h0001;
    repeat (4) send_tick(scan_columns(1'b0));
    keys_down = 16'h8000;
    repeat (4) send_tick(scan_columns(1'b0));
  endtask

  task automatic test_ghost_scan();
    keys_down = 16'hFFFF;
    repeat (4) send_tick(scan_columns(1'b0));
  endtask

  task automatic test_empty_scan();
    keys_down = '0;
    repeat (4) send_tick(scan_columns(1'b0));
  endtask

  task automatic test_masked_keys();
    wait_drained();
    write_reg(ADDR_KEY_MASK, 16'hFFF7);
    keys_down = 16'h0208;
    repeat (4) send_tick(scan_columns(1'b0));
    wait_drained();
    write_reg(ADDR_KEY_MASK, '0);
    keys_down = 16'h0001;
    repeat (4) send_tick(scan_columns(1'b0));
  endtask

  // longest settle; the next segment lowers it while the row is mid-wait
  task automatic test_settle_max();
    wait_drained();
    write_reg(ADDR_SETTLE, 16'hFFFF);
    repeat (4) send_tick(scan_columns(1'b1));
  endtask

  task automatic test_random_traffic();
    int budget;
    int seg_len;
    logic [15:0] val;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin src_idle_pct = 37; sink_idle_pct = 84; end
        1: begin src_idle_pct = 84; sink_idle_pct = 37; end
        default: begin src_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      budget = RANDOM_ITEMS / 3;
      while (budget > 0) begin
        wait_drained();
        case ($urandom_range(9))
          0: val = '0;
          1: val = 16'($urandom_range(16'hFFFF));
          default: val = 16'($urandom_range(1, 6));
        endcase
        write_reg(ADDR_SETTLE, val);
        case ($urandom_range(9))
          0: val = '0;
          1: val = 16'hFFFF;
          2, 3: val = 16'($urandom_range(16'hFFFF));
          default: val = ~((16'h1 << $urandom_range(15)) | (16'h1 << $urandom_range(15)));
        endcase
        write_reg(ADDR_KEY_MASK, val);
        keys_down = pick_key_set();
        seg_len = $urandom_range(25, 60);
        if (seg_len > budget) seg_len = budget;
        repeat (seg_len) begin
          send_tick(scan_columns(1'b1));
          if (last_done) keys_down = pick_key_set();
        end
        budget -= seg_len;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(negedge clk);
    test_reset_defaults();
    test_single_key();
    test_ghost_scan();
    test_empty_scan();
    test_masked_keys();
    test_settle_max();
    test_random_traffic();
    wait_drained();
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("matrix_keypad_scanner verification clean");
    end else begin
      $display("matrix_keypad_scanner verification failed");
    end
    $finish;
  end

endmodule
